// ===== design/dpb_pkg.sv =====
package dpb_pkg;

  localparam int unsigned PixelBits    = 10;
  localparam int unsigned DepthBits    = 16;
  localparam int unsigned CoordBits    = 10;
  localparam int unsigned CoefFracBits = 28;
  localparam int unsigned ColBits      = (CoordBits < PixelBits) ? CoordBits : PixelBits;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 64;

  // Divide-by-1000 unit: a 48-bit dividend taken 16 bits per step.
  localparam int unsigned NumBits    = 48;
  localparam int unsigned DigitBits  = 16;
  localparam int unsigned DivSteps   = NumBits / DigitBits;
  localparam int unsigned RemBits    = 10;
  localparam int unsigned RecipBits  = 29;
  localparam int unsigned RecipShift = 38;
  localparam logic [RemBits-1:0]   DivK   = 10'd1000;
  localparam logic [RecipBits-1:0] RecipM = 29'd274877907;
  localparam int unsigned PreShift   = CoefFracBits - 16;

  localparam logic signed [31:0] One   = 32'sd1 <<< CoefFracBits;
  localparam logic signed [64:0] QHalf = 65'sd1 <<< (CoefFracBits - 1);
  localparam logic signed [48:0] PHalf = 49'sd500 <<< PreShift;
  localparam logic signed [64:0] Max32 = 65'sd2147483647;
  localparam logic signed [64:0] Min32 = -65'sd2147483648;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_INV_FOCAL_X,
    CFG_INV_OFFSET_X,
    CFG_INV_FOCAL_Y,
    CFG_INV_OFFSET_Y,
    CFG_RADIAL_K1,
    CFG_RADIAL_K2,
    CFG_RADIAL_K3,
    CFG_TANGENTIAL_PAIR
  } cfg_idx_e;

  typedef struct packed {
    logic [PixelBits-1:0]        pixel_col;
    logic [PixelBits-1:0]        pixel_row;
    logic signed [DepthBits-1:0] depth_raw;
  } pix_req_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic               neg;
    logic [NumBits-1:0] num;
    logic [RemBits-1:0] rem;
    logic [NumBits-1:0] quo;
  } div_lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > Max32) begin
      return 32'(Max32);
    end else if (v < Min32) begin
      return 32'(Min32);
    end
    return 32'(v);
  endfunction

  // Fixed-point product rescale, rounding half away from zero.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [64:0] w;
    w = p[63] ? (65'(p) + QHalf - 65'sd1) : (65'(p) + QHalf);
    return sat32(w >>> CoefFracBits);
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat32(65'(a) + 65'(b));
  endfunction

  // Magnitude of c*depth with the rounding offset added and the 2^(F-16) scale removed.
  function automatic div_lane_t mk_lane(input logic signed [NumBits-1:0] p);
    logic signed [48:0] w;
    logic signed [48:0] a;
    div_lane_t          l;
    w     = 49'(p);
    a     = p[NumBits-1] ? (PHalf - w) : (w + PHalf);
    l.neg = p[NumBits-1];
    l.num = NumBits'(a >>> PreShift);
    l.rem = '0;
    l.quo = '0;
    return l;
  endfunction

  function automatic div_lane_t mk_zlane(input logic signed [DepthBits-1:0] d);
    logic [DepthBits:0] mag;
    div_lane_t          l;
    mag   = d[DepthBits-1] ? (17'(17'sd0 - 17'(d))) : 17'(d);
    l.neg = d[DepthBits-1];
    l.num = (NumBits'(mag) << 16) + NumBits'(500);
    l.rem = '0;
    l.quo = '0;
    return l;
  endfunction

  // One quotient digit: the remainder stays below 1000, so n < 1000 * 2^16 and
  // the reciprocal product is exact without correction.
  function automatic div_lane_t dstep(input div_lane_t l);
    logic [RemBits+DigitBits-1:0]           n;
    logic [RemBits+DigitBits+RecipBits-1:0] prod;
    logic [DigitBits-1:0]                   q;
    logic [RemBits+DigitBits-1:0]           qk;
    div_lane_t                              o;
    n     = {l.rem, l.num[NumBits-1 -: DigitBits]};
    prod  = (RemBits+DigitBits+RecipBits)'(n) * (RemBits+DigitBits+RecipBits)'(RecipM);
    q     = prod[RecipShift +: DigitBits];
    qk    = (RemBits+DigitBits)'(q) * (RemBits+DigitBits)'(DivK);
    o.neg = l.neg;
    o.num = l.num << DigitBits;
    o.quo = {l.quo[NumBits-DigitBits-1:0], q};
    o.rem = RemBits'(n - qk);
    return o;
  endfunction

  function automatic logic signed [31:0] fin32(input div_lane_t l);
    if (l.neg) begin
      if (l.quo > NumBits'(48'h0_8000_0000)) begin
        return 32'(Min32);
      end
      return 32'(NumBits'(0) - l.quo);
    end
    if (l.quo > NumBits'(48'h0_7FFF_FFFF)) begin
      return 32'(Max32);
    end
    return 32'(l.quo);
  endfunction

endpackage

// ===== design/depth_pixel_backprojection.sv =====
// Throughput: one request per cycle unless a stalled output backs it up; the 20-stage
// pipeline carries a valid bit per stage and each stage advances when the one after
// it is empty or advancing.
// The final divide by 1000 is three 16-bit digit stages of a reciprocal multiply.
// Reset clears all stage valid bits and sets every configuration register to zero.
module depth_pixel_backprojection (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpb_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [dpb_pkg::CfgDataBits-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  dpb_pkg::pix_req_t               in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output dpb_pkg::point_t                 out_o
);
  import dpb_pkg::*;

  localparam int unsigned DivBase = 15;
  localparam int unsigned NStg    = DivBase + DivSteps + 2;
  localparam int unsigned Last    = NStg - 1;

  // Configuration registers.
  logic signed [31:0] ifx_q, iox_q, ify_q, ioy_q, k1_q, k2_q, k3_q;
  logic [63:0]        tp_q;
  logic signed [31:0] p1, p2;

  assign p1 = $signed(tp_q[31:0]);
  assign p2 = $signed(tp_q[63:32]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ifx_q <= '0;
      iox_q <= '0;
      ify_q <= '0;
      ioy_q <= '0;
      k1_q  <= '0;
      k2_q  <= '0;
      k3_q  <= '0;
      tp_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_INV_FOCAL_X:     ifx_q <= $signed(cfg_wdata_i[31:0]);
        CFG_INV_OFFSET_X:    iox_q <= $signed(cfg_wdata_i[31:0]);
        CFG_INV_FOCAL_Y:     ify_q <= $signed(cfg_wdata_i[31:0]);
        CFG_INV_OFFSET_Y:    ioy_q <= $signed(cfg_wdata_i[31:0]);
        CFG_RADIAL_K1:       k1_q  <= $signed(cfg_wdata_i[31:0]);
        CFG_RADIAL_K2:       k2_q  <= $signed(cfg_wdata_i[31:0]);
        CFG_RADIAL_K3:       k3_q  <= $signed(cfg_wdata_i[31:0]);
        CFG_TANGENTIAL_PAIR: tp_q  <= cfg_wdata_i[63:0];
        default:             tp_q  <= tp_q;
      endcase
    end
  end

  // Stage valid bits and the advance chain.
  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  assign en[Last] = !vld_q[Last] || out_ready_i;
  for (genvar k = 0; k < Last; k++) begin : g_adv
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 0 operands.
  logic signed [ColBits:0]    col_s, row_s;
  logic signed [ColBits+32:0] mcol, mrow;

  always_comb begin
    col_s = $signed({1'b0, in_req_i.pixel_col[ColBits-1:0]});
    row_s = $signed({1'b0, in_req_i.pixel_row[ColBits-1:0]});
    mcol  = col_s * ifx_q;
    mrow  = row_s * ify_q;
  end

  logic signed [31:0] x0_q, y0_q, x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic signed [31:0] x5_q, y5_q, x6_q, y6_q, x7_q, y7_q, x8_q, y8_q, x9_q, y9_q;
  logic signed [31:0] x10_q, y10_q;
  logic signed [DepthBits-1:0] d0_q, d1_q, d2_q, d3_q, d4_q, d5_q, d6_q, d7_q;
  logic signed [DepthBits-1:0] d8_q, d9_q, d10_q, d11_q, d12_q, d13_q, d14_q;
  logic signed [63:0] pxx1_q, pyy1_q, pxy1_q;
  logic signed [31:0] xx2_q, yy2_q, xy2_q;
  logic signed [31:0] r2_3_q, t3_q, xx3_q, yy3_q;
  logic signed [63:0] pr4_4_q, pk1_4_q;
  logic signed [31:0] ux4_q, uy4_q, t4_q, r2_4_q;
  logic signed [31:0] r4_5_q, qk1_5_q, r2_5_q;
  logic signed [63:0] ptx1_5_q, pty1_5_q, ptx2_5_q, pty2_5_q;
  logic signed [63:0] pr6_6_q, pk2_6_q;
  logic signed [31:0] qtx1_6_q, qty1_6_q, qtx2_6_q, qty2_6_q, qk1_6_q;
  logic signed [31:0] r6_7_q, qk2_7_q, tx7_q, ty7_q, qk1_7_q;
  logic signed [63:0] pk3_8_q;
  logic signed [31:0] qk1_8_q, qk2_8_q, tx8_q, ty8_q;
  logic signed [31:0] qk3_9_q, tx9_q, ty9_q;
  logic signed [33:0] s0_9_q;
  logic signed [31:0] s10_q, tx10_q, ty10_q;
  logic signed [63:0] pxs11_q, pys11_q;
  logic signed [31:0] tx11_q, ty11_q;
  logic signed [31:0] qxs12_q, qys12_q, tx12_q, ty12_q;
  logic signed [31:0] cx13_q, cy13_q;
  logic signed [NumBits-1:0] pcx14_q, pcy14_q;
  div_lane_t lx_q [DivSteps+1];
  div_lane_t ly_q [DivSteps+1];
  div_lane_t lz_q [DivSteps+1];
  point_t    out_q;

  always_ff @(posedge clk_i) begin
    // Normalized coordinates.
    if (en[0]) begin
      x0_q <= sat32(65'(mcol) + 65'(iox_q));
      y0_q <= sat32(65'(mrow) + 65'(ioy_q));
      d0_q <= in_req_i.depth_raw;
    end
    if (en[1]) begin
      pxx1_q <= x0_q * x0_q;
      pyy1_q <= y0_q * y0_q;
      pxy1_q <= x0_q * y0_q;
      x1_q   <= x0_q;
      y1_q   <= y0_q;
      d1_q   <= d0_q;
    end
    if (en[2]) begin
      xx2_q <= qround(pxx1_q);
      yy2_q <= qround(pyy1_q);
      xy2_q <= qround(pxy1_q);
      x2_q  <= x1_q;
      y2_q  <= y1_q;
      d2_q  <= d1_q;
    end
    if (en[3]) begin
      r2_3_q <= add_sat(xx2_q, yy2_q);
      t3_q   <= sat32(65'(xy2_q) <<< 1);
      xx3_q  <= xx2_q;
      yy3_q  <= yy2_q;
      x3_q   <= x2_q;
      y3_q   <= y2_q;
      d3_q   <= d2_q;
    end
    if (en[4]) begin
      pr4_4_q <= r2_3_q * r2_3_q;
      pk1_4_q <= k1_q * r2_3_q;
      ux4_q   <= sat32(65'(r2_3_q) + (65'(xx3_q) <<< 1));
      uy4_q   <= sat32(65'(r2_3_q) + (65'(yy3_q) <<< 1));
      t4_q    <= t3_q;
      r2_4_q  <= r2_3_q;
      x4_q    <= x3_q;
      y4_q    <= y3_q;
      d4_q    <= d3_q;
    end
    if (en[5]) begin
      r4_5_q   <= qround(pr4_4_q);
      qk1_5_q  <= qround(pk1_4_q);
      ptx1_5_q <= p1 * t4_q;
      pty1_5_q <= p2 * t4_q;
      ptx2_5_q <= p2 * ux4_q;
      pty2_5_q <= p1 * uy4_q;
      r2_5_q   <= r2_4_q;
      x5_q     <= x4_q;
      y5_q     <= y4_q;
      d5_q     <= d4_q;
    end
    if (en[6]) begin
      pr6_6_q  <= r2_5_q * r4_5_q;
      pk2_6_q  <= k2_q * r4_5_q;
      qtx1_6_q <= qround(ptx1_5_q);
      qty1_6_q <= qround(pty1_5_q);
      qtx2_6_q <= qround(ptx2_5_q);
      qty2_6_q <= qround(pty2_5_q);
      qk1_6_q  <= qk1_5_q;
      x6_q     <= x5_q;
      y6_q     <= y5_q;
      d6_q     <= d5_q;
    end
    if (en[7]) begin
      r6_7_q  <= qround(pr6_6_q);
      qk2_7_q <= qround(pk2_6_q);
      tx7_q   <= add_sat(qtx1_6_q, qtx2_6_q);
      ty7_q   <= add_sat(qty1_6_q, qty2_6_q);
      qk1_7_q <= qk1_6_q;
      x7_q    <= x6_q;
      y7_q    <= y6_q;
      d7_q    <= d6_q;
    end
    if (en[8]) begin
      pk3_8_q <= k3_q * r6_7_q;
      qk1_8_q <= qk1_7_q;
      qk2_8_q <= qk2_7_q;
      tx8_q   <= tx7_q;
      ty8_q   <= ty7_q;
      x8_q    <= x7_q;
      y8_q    <= y7_q;
      d8_q    <= d7_q;
    end
    // Radial scale: the partial sum stays wide, saturation happens once at the end.
    if (en[9]) begin
      qk3_9_q <= qround(pk3_8_q);
      s0_9_q  <= 34'(One) + 34'(qk1_8_q) + 34'(qk2_8_q);
      tx9_q   <= tx8_q;
      ty9_q   <= ty8_q;
      x9_q    <= x8_q;
      y9_q    <= y8_q;
      d9_q    <= d8_q;
    end
    if (en[10]) begin
      s10_q  <= sat32(65'(s0_9_q) + 65'(qk3_9_q));
      tx10_q <= tx9_q;
      ty10_q <= ty9_q;
      x10_q  <= x9_q;
      y10_q  <= y9_q;
      d10_q  <= d9_q;
    end
    if (en[11]) begin
      pxs11_q <= x10_q * s10_q;
      pys11_q <= y10_q * s10_q;
      tx11_q  <= tx10_q;
      ty11_q  <= ty10_q;
      d11_q   <= d10_q;
    end
    if (en[12]) begin
      qxs12_q <= qround(pxs11_q);
      qys12_q <= qround(pys11_q);
      tx12_q  <= tx11_q;
      ty12_q  <= ty11_q;
      d12_q   <= d11_q;
    end
    if (en[13]) begin
      cx13_q <= add_sat(qxs12_q, tx12_q);
      cy13_q <= add_sat(qys12_q, ty12_q);
      d13_q  <= d12_q;
    end
    if (en[14]) begin
      pcx14_q <= cx13_q * d13_q;
      pcy14_q <= cy13_q * d13_q;
      d14_q   <= d13_q;
    end
    // Rounded divide by 1000 in sign-magnitude form, one digit per stage.
    if (en[DivBase]) begin
      lx_q[0] <= mk_lane(pcx14_q);
      ly_q[0] <= mk_lane(pcy14_q);
      lz_q[0] <= mk_zlane(d14_q);
    end
    for (int i = 1; i <= DivSteps; i++) begin
      if (en[DivBase+i]) begin
        lx_q[i] <= dstep(lx_q[i-1]);
        ly_q[i] <= dstep(ly_q[i-1]);
        lz_q[i] <= dstep(lz_q[i-1]);
      end
    end
    if (en[Last]) begin
      out_q.point_x <= fin32(lx_q[DivSteps]);
      out_q.point_y <= fin32(ly_q[DivSteps]);
      out_q.point_z <= fin32(lz_q[DivSteps]);
    end
  end

  assign out_o = out_q;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // An empty output register always lets the whole pipeline advance.
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request refused while the output register is empty");

  // Requests in flight change only by what is accepted and delivered.
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rst_ni |=> $countones(vld_q) ==
               $past($countones(vld_q)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("request lost or duplicated in the pipeline");

  // A full pipeline with a stalled output takes nothing new.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("request accepted into a full stalled pipeline");

endmodule

// ===== verif/dpb_checker.sv =====
module dpb_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpb_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [dpb_pkg::CfgDataBits-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  dpb_pkg::pix_req_t               in_req_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  dpb_pkg::point_t                 out_i,
  output int                              mismatch_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dpb_pkg::*;

  localparam longint          WordMax    = 64'sd2147483647;
  localparam longint          WordMin    = -64'sd2147483648;
  localparam longint          FxUnit     = 64'sd1 <<< CoefFracBits;
  localparam longint unsigned FxScale    = 64'd1 << CoefFracBits;
  localparam longint unsigned PointScale = 64'd1000 << CoefFracBits;
  localparam int              ReportMax  = 10;

  typedef struct packed {
    pix_req_t req;
    point_t   pt;
  } awaited_point_t;

  logic signed [31:0] inv_fx, inv_ox, inv_fy, inv_oy;
  logic signed [31:0] k1, k2, k3;
  logic        [63:0] tang_pair;

  awaited_point_t points_due[$];

  function automatic longint clamp32(input longint v);
    if (v > WordMax) return WordMax;
    if (v < WordMin) return WordMin;
    return v;
  endfunction

  // Rounds to nearest with ties away from zero.
  function automatic longint round_div(input longint num, input longint unsigned den);
    longint unsigned mag;
    longint unsigned quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -$signed(quo) : $signed(quo);
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    return clamp32(round_div(a * b, FxScale));
  endfunction

  function automatic point_t backproject(input pix_req_t r);
    longint col, row, depth, p1, p2;
    longint x, y, x2, y2, xy, r2, r4, r6, s, t, tx, ty, cx, cy;
    point_t pt;
    col   = r.pixel_col & ((1 << CoordBits) - 1);
    row   = r.pixel_row & ((1 << CoordBits) - 1);
    depth = r.depth_raw;
    p1    = $signed(tang_pair[31:0]);
    p2    = $signed(tang_pair[63:32]);

    x  = clamp32(col * inv_fx + inv_ox);
    y  = clamp32(row * inv_fy + inv_oy);
    x2 = fx_mul(x, x);
    y2 = fx_mul(y, y);
    xy = fx_mul(x, y);
    r2 = clamp32(x2 + y2);
    r4 = fx_mul(r2, r2);
    r6 = fx_mul(r2, r4);
    // The radial sum saturates once, after all four terms are added.
    s  = clamp32(FxUnit + fx_mul(k1, r2) + fx_mul(k2, r4) + fx_mul(k3, r6));
    t  = clamp32(2 * xy);
    tx = clamp32(fx_mul(p1, t) + fx_mul(p2, clamp32(r2 + 2 * x2)));
    ty = clamp32(fx_mul(p2, t) + fx_mul(p1, clamp32(r2 + 2 * y2)));
    cx = clamp32(fx_mul(x, s) + tx);
    cy = clamp32(fx_mul(y, s) + ty);

    pt.point_x = 32'(clamp32(round_div(cx * depth * 65536, PointScale)));
    pt.point_y = 32'(clamp32(round_div(cy * depth * 65536, PointScale)));
    pt.point_z = 32'(clamp32(round_div(depth * 65536, 1000)));
    return pt;
  endfunction

  task automatic check_field(input string name, input pix_req_t req,
                             input logic signed [31:0] want, input logic signed [31:0] got);
    if (got !== want) begin
      mismatch_count_o++;
      if (mismatch_count_o <= ReportMax) begin
        $display("%t: %s mismatch for col %0d row %0d depth %0d: expected %0d, got %0d",
                 $time, name, req.pixel_col, req.pixel_row, req.depth_raw, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    awaited_point_t due;
    if (!rst_ni) begin
      inv_fx    = '0;
      inv_ox    = '0;
      inv_fy    = '0;
      inv_oy    = '0;
      k1        = '0;
      k2        = '0;
      k3        = '0;
      tang_pair = '0;
      points_due.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_INV_FOCAL_X:     inv_fx    = cfg_wdata_i[31:0];
          CFG_INV_OFFSET_X:    inv_ox    = cfg_wdata_i[31:0];
          CFG_INV_FOCAL_Y:     inv_fy    = cfg_wdata_i[31:0];
          CFG_INV_OFFSET_Y:    inv_oy    = cfg_wdata_i[31:0];
          CFG_RADIAL_K1:       k1        = cfg_wdata_i[31:0];
          CFG_RADIAL_K2:       k2        = cfg_wdata_i[31:0];
          CFG_RADIAL_K3:       k3        = cfg_wdata_i[31:0];
          CFG_TANGENTIAL_PAIR: tang_pair = cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (points_due.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= ReportMax) begin
            $display("%t: point x %0d y %0d z %0d arrived with no request outstanding",
                     $time, out_i.point_x, out_i.point_y, out_i.point_z);
          end
        end else begin
          due = points_due.pop_front();
          check_field("point_x", due.req, due.pt.point_x, out_i.point_x);
          check_field("point_y", due.req, due.pt.point_y, out_i.point_y);
          check_field("point_z", due.req, due.pt.point_z, out_i.point_z);
        end
      end

      if (in_valid_i && in_ready_i) begin
        due.req = in_req_i;
        due.pt  = backproject(in_req_i);
        points_due = {points_due, due};
      end
      pending_o = points_due.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dpb_pkg::*;

  localparam int HoldCycles = 400;
  localparam int StallLimit = 3000;
  localparam int PhaseItems = 250;
  localparam int NumPhases  = 8;
  localparam int DrainWait  = 30;

  typedef enum int {
    SET_ZERO,
    SET_CAMERA,
    SET_MAX,
    SET_MIN,
    SET_MODERATE,
    SET_RANDOM
  } setting_e;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  cfg_idx_e               cfg_idx;
  logic [CfgDataBits-1:0] cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  pix_req_t               in_req;
  logic                   out_valid;
  logic                   out_ready;
  point_t                 out_pt;

  int mismatches;
  int pending;
  int stall_cycles;
  bit in_idle;
  bit out_idle;
  bit hold_output;

  depth_pixel_backprojection i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_pt)
  );

  dpb_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_i            (out_pt),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int spread(input int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // The upper half of the write data is noise for the 32-bit registers.
  task automatic write_setting(input setting_e kind);
    logic [31:0] fx, ox, fy, oy, c1, c2, c3;
    logic [63:0] tp;
    case (kind)
      SET_ZERO: begin
        {fx, ox, fy, oy, c1, c2, c3} = '0;
        tp = '0;
      end
      SET_CAMERA: begin
        fx = 32'(511305 + spread(3000));
        fy = 32'(int'(fx) + spread(500));
        ox = 32'(-320 * int'(fx) + spread(1 << 20));
        oy = 32'(-240 * int'(fy) + spread(1 << 20));
        c1 = 32'(-75161928 + spread(1 << 22));
        c2 = 32'(24159191 + spread(1 << 21));
        c3 = 32'(-2684355 + spread(1 << 20));
        tp = {32'(-187905 + spread(1 << 16)), 32'(322123 + spread(1 << 16))};
      end
      SET_MAX: begin
        {fx, ox, fy, oy, c1, c2, c3} = {7{32'h7FFF_FFFF}};
        tp = 64'h7FFF_FFFF_7FFF_FFFF;
      end
      SET_MIN: begin
        {fx, ox, fy, oy, c1, c2, c3} = {7{32'h8000_0000}};
        tp = 64'h8000_0000_8000_0000;
      end
      SET_MODERATE: begin
        fx = 32'(spread(1 << 22));
        fy = 32'(spread(1 << 22));
        ox = 32'(spread(1 << 29));
        oy = 32'(spread(1 << 29));
        c1 = 32'(spread(1 << 27));
        c2 = 32'(spread(1 << 27));
        c3 = 32'(spread(1 << 27));
        tp = {32'(spread(1 << 22)), 32'(spread(1 << 22))};
      end
      default: begin
        fx = $urandom;
        ox = $urandom;
        fy = $urandom;
        oy = $urandom;
        c1 = $urandom;
        c2 = $urandom;
        c3 = $urandom;
        tp = {$urandom, $urandom};
      end
    endcase
    write_reg(CFG_INV_FOCAL_X, {32'($urandom), fx});
    write_reg(CFG_INV_OFFSET_X, {32'($urandom), ox});
    write_reg(CFG_INV_FOCAL_Y, {32'($urandom), fy});
    write_reg(CFG_INV_OFFSET_Y, {32'($urandom), oy});
    write_reg(CFG_RADIAL_K1, {32'($urandom), c1});
    write_reg(CFG_RADIAL_K2, {32'($urandom), c2});
    write_reg(CFG_RADIAL_K3, {32'($urandom), c3});
    write_reg(CFG_TANGENTIAL_PAIR, tp);
    cfg_we <= 1'b0;
  endtask

  function automatic pix_req_t rand_pixel();
    pix_req_t r;
    r.pixel_col = PixelBits'($urandom);
    r.pixel_row = PixelBits'($urandom);
    case ($urandom_range(0, 4))
      0, 1: r.depth_raw = DepthBits'($urandom);
      2, 3: r.depth_raw = DepthBits'($urandom_range(0, 10000));
      default: begin
        case ($urandom_range(0, 3))
          0: r.depth_raw = 16'sh7FFF;
          1: r.depth_raw = 16'sh8000;
          2: r.depth_raw = 16'sh0000;
          default: r.depth_raw = 16'shFFFF;
        endcase
      end
    endcase
    return r;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_pixel(input pix_req_t r);
    int gap;
    gap = in_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Receiver: draws a pause per point and, when asked, holds off once long enough
  // to back the pipeline up into the input.
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_output && !held) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        held = 1'b1;
      end
      gap = out_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  initial begin
    pix_req_t corner_pixels [8];
    setting_e corner_settings [2];
    setting_e phase_settings [NumPhases];
    corner_pixels = '{
      {10'd0,    10'd0,    16'h0000},
      {10'd1023, 10'd1023, 16'h7FFF},
      {10'd0,    10'd1023, 16'h8000},
      {10'd1023, 10'd0,    16'hFFFF},
      {10'd320,  10'd240,  16'd1000},
      {10'd640,  10'd480,  16'd1},
      {10'd1,    10'd1023, 16'hFC18},
      {10'd512,  10'd512,  16'd12345}
    };
    corner_settings = '{SET_CAMERA, SET_MAX};
    phase_settings  = '{SET_CAMERA, SET_MAX, SET_MODERATE, SET_MIN,
                        SET_RANDOM, SET_CAMERA, SET_ZERO, SET_MODERATE};

    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_INV_FOCAL_X;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_req    <= '0;
    in_idle     = 1'b0;
    out_idle    = 1'b0;
    hold_output = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner pixels first with the registers as reset left them, then under a
    // plausible camera and with every coefficient at its maximum.
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    finish_burst();
    foreach (corner_settings[s]) begin
      write_setting(corner_settings[s]);
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      finish_burst();
    end

    for (int p = 0; p < NumPhases; p++) begin
      write_setting(phase_settings[p]);
      in_idle     = (p % 3 != 1);
      out_idle    = (p % 4 != 2);
      hold_output = (p == 0);
      repeat (PhaseItems) send_pixel(rand_pixel());
      finish_burst();
    end

    repeat (DrainWait) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
